FILE: sv/msfd_pkg.sv
// package: phase and event codes, magic bytes and crc-32 nibble table for the deframer
package msfd_pkg;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_TYPE    = 3'd1,
      PH_FLAGS   = 3'd2,
      PH_LEN0    = 3'd3,
      PH_LEN1    = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CRC     = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_FRAME    = 3'd1,
      EV_BADFLAGS = 3'd2,
      EV_BADLEN   = 3'd3,
      EV_BADCRC   = 3'd4
   } event_type;

   localparam int unsigned MAGIC_LEN = 4;
   localparam logic [7:0] MAGIC_SEQ [MAGIC_LEN] = '{8'hA5, 8'h48, 8'h58, 8'h44};

   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;
   localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;

   localparam logic [31:0] NIB_TAB [16] = '{
      32'h00000000, 32'h1DB71064, 32'h3B6E20C8, 32'h26D930AC,
      32'h76DC4190, 32'h6B6B51F4, 32'h4DB26158, 32'h5005713C,
      32'hEDB88320, 32'hF00F9344, 32'hD6D6A3E8, 32'hCB61B38C,
      32'h9B64C2B0, 32'h86D3D2D4, 32'hA00AE278, 32'hBDBDF21C
   };

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] v);
      logic [31:0] t;
      t = c ^ {24'd0, v};
      t = (t >> 4) ^ NIB_TAB[t[3:0]];
      t = (t >> 4) ^ NIB_TAB[t[3:0]];
      return t;
   endfunction

endpackage

FILE: sv/msfd_if.sv
// interfaces: received byte channel and result channel
interface msfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msfd_rsp_if;
   logic                 valid;
   logic                 ready;
   msfd_pkg::event_type  event_res;
   logic [7:0]           frame_type;
   logic [15:0]          frame_length;
   logic                 payload_valid;
   logic [7:0]           payload_byte;
   logic [15:0]          payload_index;

   modport source (output valid, output event_res, output frame_type, output frame_length,
                   output payload_valid, output payload_byte, output payload_index,
                   input ready);
   modport sink   (input valid, input event_res, input frame_type, input frame_length,
                   input payload_valid, input payload_byte, input payload_index,
                   output ready);
endinterface

FILE: sv/magic_sync_frame_deframer_crc32.sv
// top level: magic-sync frame deframer with crc-32 check, one received byte per item
//
//  channel  direction  contents
//  req      in         rx_byte
//  rsp      out        event_res, frame_type, frame_length, payload_valid/byte/index
//  csr      in (apb)   max_payload at byte address 0
//
//  one item per cycle sustained unless rsp stalls; path: input register, then result register
//  the parse step and one crc byte update (two nibble lookups) sit between the registers
//  rsp stall holds the result register; the input register takes one more item, then req stalls
//  synchronous active-high reset returns to hunting with max_payload 4096
module magic_sync_frame_deframer_crc32 (
   input  logic                           clock,
   input  logic                           reset,
   msfd_req_if.sink                       req,
   msfd_rsp_if.source                     rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [msfd_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [msfd_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [msfd_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import msfd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   event_type   out_event_ff, event_in;
   logic [7:0]  out_type_ff;
   logic [15:0] out_length_ff;
   logic        out_pv_ff, pv_in;
   logic [7:0]  out_pb_ff, pb_in;
   logic [15:0] out_pi_ff, pi_in;

   logic [15:0] max_payload_ff;
   phase_type   phase_ff, phase_in;
   logic [1:0]  magic_ff, magic_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] wire_ff, wire_in;
   logic [1:0]  seen_ff, seen_in;

   logic        advance;
   logic [31:0] crc_step;
   logic [15:0] len_full;
   logic [15:0] count_next;
   logic [31:0] wire_full;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready  = !in_valid_ff || advance;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DW-16){1'b0}}, max_payload_ff};

   assign crc_step   = crc_byte((phase_ff == PH_TYPE) ? CRC_INIT : crc_ff, in_byte_ff);
   assign len_full   = {in_byte_ff, length_ff[7:0]};
   assign count_next = count_ff + 16'd1;
   assign wire_full  = wire_ff | ({24'd0, in_byte_ff} << {seen_ff, 3'b000});

   always_comb begin
      phase_in  = phase_ff;
      magic_in  = magic_ff;
      type_in   = type_ff;
      length_in = length_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      wire_in   = wire_ff;
      seen_in   = seen_ff;
      event_in  = EV_NONE;
      pv_in     = 1'b0;
      pb_in     = 8'd0;
      pi_in     = 16'd0;
      case (phase_ff)
         PH_HUNT: begin
            if (in_byte_ff == MAGIC_SEQ[magic_ff]) begin
               magic_in = magic_ff + 2'd1;
               if (magic_ff == 2'd3) begin
                  phase_in = PH_TYPE;
               end
            end else begin
               magic_in = (in_byte_ff == MAGIC_SEQ[0]) ? 2'd1 : 2'd0;
            end
         end
         PH_TYPE: begin
            type_in  = in_byte_ff;
            crc_in   = crc_step;
            phase_in = PH_FLAGS;
         end
         PH_FLAGS: begin
            crc_in = crc_step;
            if (in_byte_ff != 8'd0) begin
               phase_in = PH_HUNT;
               magic_in = 2'd0;
               event_in = EV_BADFLAGS;
            end else begin
               phase_in = PH_LEN0;
            end
         end
         PH_LEN0: begin
            crc_in    = crc_step;
            length_in = {8'd0, in_byte_ff};
            phase_in  = PH_LEN1;
         end
         PH_LEN1: begin
            crc_in    = crc_step;
            length_in = len_full;
            if (len_full > max_payload_ff) begin
               phase_in = PH_HUNT;
               magic_in = 2'd0;
               event_in = EV_BADLEN;
            end else begin
               count_in = 16'd0;
               seen_in  = 2'd0;
               wire_in  = 32'd0;
               phase_in = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            pv_in    = 1'b1;
            pb_in    = in_byte_ff;
            pi_in    = count_ff;
            crc_in   = crc_step;
            count_in = count_next;
            if (count_next == 16'd0 || count_next >= length_ff) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            wire_in = wire_full;
            seen_in = seen_ff + 2'd1;
            if (seen_ff == 2'd3) begin
               phase_in = PH_HUNT;
               magic_in = 2'd0;
               event_in = (wire_full == ~crc_ff) ? EV_FRAME : EV_BADCRC;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            magic_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
         phase_ff       <= PH_HUNT;
         magic_ff       <= 2'd0;
         type_ff        <= 8'd0;
         length_ff      <= 16'd0;
         count_ff       <= 16'd0;
         crc_ff         <= CRC_INIT;
         wire_ff        <= 32'd0;
         seen_ff        <= 2'd0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_MAX_PAYLOAD) begin
            max_payload_ff <= csr_pwdata[15:0];
         end
         if (advance) begin
            phase_ff  <= phase_in;
            magic_ff  <= magic_in;
            type_ff   <= type_in;
            length_ff <= length_in;
            count_ff  <= count_in;
            crc_ff    <= crc_in;
            wire_ff   <= wire_in;
            seen_ff   <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.rx_byte;
      end
      if (advance) begin
         out_event_ff  <= event_in;
         out_type_ff   <= type_in;
         out_length_ff <= length_in;
         out_pv_ff     <= pv_in;
         out_pb_ff     <= pb_in;
         out_pi_ff     <= pi_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.event_res     = out_event_ff;
   assign rsp.frame_type    = out_type_ff;
   assign rsp.frame_length  = out_length_ff;
   assign rsp.payload_valid = out_pv_ff;
   assign rsp.payload_byte  = out_pb_ff;
   assign rsp.payload_index = out_pi_ff;

   a_payload_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload_valid |-> rsp.event_res == EV_NONE)
      else $error("payload item carries an event");

   a_event_to_hunt: assert property (@(posedge clock) disable iff (reset)
      advance && event_in != EV_NONE |=> phase_ff == PH_HUNT && magic_ff == 2'd0)
      else $error("frame event without return to hunting");

   a_magic_only_hunting: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HUNT |-> magic_ff == 2'd0)
      else $error("magic match count outside hunting");

   a_payload_bounds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> length_ff != 16'd0 && count_ff < length_ff)
      else $error("payload count out of range");

   a_crc_seen_phase: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd0 |-> phase_ff == PH_CRC)
      else $error("crc byte count outside crc phase");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(out_event_ff))
      else $error("stalled result overwritten");

endmodule
